### sv/rgbhsv_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the RGB to HSV converter.
// No dependencies; imported by rgbhsv_div, rgb_to_hsv_fixed_point and the bench files.
package rgbhsv_pkg;

  localparam int CH_W   = 10;  // channel and quotient width
  localparam int SEG_W  = 5;
  localparam int FULL_W = 13;

  // Divider split: DIV_STAGES * DIV_STEPS_PER_STAGE quotient bits
  localparam int DIV_STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES          = 5;

  localparam logic [CH_W-1:0] QUO_CAP = 10'd1023;

  // Segment base per dominant channel and sub-branch
  localparam logic [SEG_W-1:0] SEG_RED_HI   = 5'd0;
  localparam logic [SEG_W-1:0] SEG_RED_LO   = 5'd20;
  localparam logic [SEG_W-1:0] SEG_GREEN_HI = 5'd8;
  localparam logic [SEG_W-1:0] SEG_GREEN_LO = 5'd4;
  localparam logic [SEG_W-1:0] SEG_BLUE_HI  = 5'd16;
  localparam logic [SEG_W-1:0] SEG_BLUE_LO  = 5'd12;

  typedef enum logic [1:0] {
    DIV_NORMAL,
    DIV_CAP,
    DIV_ZERO
  } div_mode_t;

  typedef struct packed {
    logic [CH_W-1:0] rem;
    logic [CH_W-1:0] den;
    logic [CH_W-1:0] quo;
    div_mode_t       mode;
  } div_stage_t;

  typedef struct packed {
    logic [CH_W-1:0]  mx;
    logic [CH_W-1:0]  mn;
    logic [SEG_W-1:0] seg_base;
  } side_t;

endpackage

### sv/rgbhsv_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: floor(1024*num/den), capped at 1023, 0 when den is 0.
// Expects num <= den. Depends on rgbhsv_pkg.
module rgbhsv_div
  import rgbhsv_pkg::*;
(
  input  logic            clk,
  input  logic            en,
  input  logic [CH_W-1:0] num,
  input  logic [CH_W-1:0] den,
  output logic [CH_W-1:0] quo
);

  div_stage_t st_r   [DIV_STAGES];
  div_stage_t st_nxt [DIV_STAGES];
  div_stage_t seed;
  div_stage_t last;

  function automatic div_stage_t div_steps(div_stage_t a);
    div_stage_t      o;
    logic [CH_W:0]   dbl;
    o = a;
    for (int k = 0; k < DIV_STEPS_PER_STAGE; k++) begin
      dbl = {o.rem, 1'b0};
      if (dbl >= {1'b0, o.den}) begin
        o.rem = CH_W'(dbl - {1'b0, o.den});
        o.quo = {o.quo[CH_W-2:0], 1'b1};
      end else begin
        o.rem = dbl[CH_W-1:0];
        o.quo = {o.quo[CH_W-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  // num == den would give exactly 1024: flag it as the cap up front
  always_comb begin
    seed.rem = num;
    seed.den = den;
    seed.quo = '0;
    if (den == '0) begin
      seed.mode = DIV_ZERO;
    end else if (num >= den) begin
      seed.mode = DIV_CAP;
    end else begin
      seed.mode = DIV_NORMAL;
    end
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign st_nxt[s] = div_steps(seed);
    end else begin : g_next
      assign st_nxt[s] = div_steps(st_r[s-1]);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

  assign last = st_r[DIV_STAGES-1];

  always_comb begin
    unique case (last.mode)
      DIV_CAP:  quo = QUO_CAP;
      DIV_ZERO: quo = '0;
      default:  quo = last.quo;
    endcase
  end

endmodule

### sv/rgb_to_hsv_fixed_point.sv
`timescale 1ns / 1ps
// RGB to display-style HSV converter, 10-bit channels, fully pipelined.
// Depends on rgbhsv_pkg and rgbhsv_div.
//
// Input channel: in_valid / in_stall with in_red, in_green, in_blue. A pixel is
// taken on a rising edge where in_valid is high and in_stall is low.
// Result channel: out_valid / out_stall with the HSV fields; a beat completes
// when out_valid is high and out_stall is low.
// Pipeline registers: input register, max/min and dividend stage, five
// divider stages of two quotient bits each, output register. Both quotients
// (saturation and hue fraction) run in parallel, in two such dividers.
// Throughput is one pixel per cycle while the receiver does not stall.
// The whole pipeline advances as one: when a result waits in the output
// register and out_stall is high, every stage holds and in_stall goes high in
// the same cycle, so nothing is dropped or repeated. Bubbles travel with the
// data and are overwritten as soon as the pipeline advances.
// Synchronous reset clears every valid bit; the block accepts a pixel in the
// first cycle after reset is released.
module rgb_to_hsv_fixed_point
  import rgbhsv_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CH_W-1:0]     in_red,
  input  logic [CH_W-1:0]     in_green,
  input  logic [CH_W-1:0]     in_blue,

  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_hue_index,
  output logic [CH_W-1:0]     out_saturation,
  output logic [CH_W-1:0]     out_value_max,
  output logic [2:0]          out_zone,
  output logic [CH_W-1:0]     out_channel_min,
  output logic [CH_W-1:0]     out_hue_fraction,
  output logic [SEG_W-1:0]    out_hue_segment,
  output logic [FULL_W-1:0]   out_hue_full
);

  localparam int VLD_N = DIV_STAGES + 2;

  logic                advance;
  logic [VLD_N-1:0]    vld_r;
  logic                out_valid_r;

  // input register
  logic [CH_W-1:0]     red_r, green_r, blue_r;

  // prep stage
  logic [CH_W-1:0]     mx_nxt, mn_nxt, span_nxt, hdiv_nxt;
  logic [SEG_W-1:0]    base_nxt;
  logic [CH_W-1:0]     mx_r, mn_r, span_r, hdiv_r;
  logic [SEG_W-1:0]    base_r;

  // side data alongside the dividers
  side_t               side_r [DIV_STAGES];
  side_t               side_out;

  logic [CH_W-1:0]     sat_quo, hue_quo;

  logic [SEG_W-1:0]    seg_nxt;
  logic [FULL_W-1:0]   full_nxt;

  logic [7:0]          hue_index_r;
  logic [CH_W-1:0]     saturation_r, value_max_r, channel_min_r, hue_fraction_r;
  logic [2:0]          zone_r;
  logic [SEG_W-1:0]    hue_segment_r;
  logic [FULL_W-1:0]   hue_full_r;

  // advance the whole pipeline unless a result is held by the receiver
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      vld_r       <= {vld_r[VLD_N-2:0], in_valid};
      out_valid_r <= vld_r[VLD_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
    end
  end

  always_comb begin
    logic red_dom, green_dom;
    red_dom   = (red_r >= green_r) && (red_r >= blue_r);
    green_dom = !red_dom && (green_r >= blue_r);

    mx_nxt = red_r;
    if (green_r > mx_nxt) mx_nxt = green_r;
    if (blue_r > mx_nxt)  mx_nxt = blue_r;
    mn_nxt = red_r;
    if (green_r < mn_nxt) mn_nxt = green_r;
    if (blue_r < mn_nxt)  mn_nxt = blue_r;
    span_nxt = mx_nxt - mn_nxt;

    if (red_dom) begin
      if (green_r >= blue_r) begin
        hdiv_nxt = green_r - blue_r;
        base_nxt = SEG_RED_HI;
      end else begin
        hdiv_nxt = red_r - blue_r;
        base_nxt = SEG_RED_LO;
      end
    end else if (green_dom) begin
      if (blue_r >= red_r) begin
        hdiv_nxt = blue_r - red_r;
        base_nxt = SEG_GREEN_HI;
      end else begin
        hdiv_nxt = green_r - red_r;
        base_nxt = SEG_GREEN_LO;
      end
    end else begin
      if (red_r >= green_r) begin
        hdiv_nxt = red_r - green_r;
        base_nxt = SEG_BLUE_HI;
      end else begin
        hdiv_nxt = blue_r - green_r;
        base_nxt = SEG_BLUE_LO;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mx_r   <= mx_nxt;
      mn_r   <= mn_nxt;
      span_r <= span_nxt;
      hdiv_r <= hdiv_nxt;
      base_r <= base_nxt;
    end
  end

  rgbhsv_div u_sat_div (
    .clk (clk),
    .en  (advance),
    .num (span_r),
    .den (mx_r),
    .quo (sat_quo)
  );

  rgbhsv_div u_hue_div (
    .clk (clk),
    .en  (advance),
    .num (hdiv_r),
    .den (span_r),
    .quo (hue_quo)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      side_r[0] <= '{mx: mx_r, mn: mn_r, seg_base: base_r};
      for (int s = 1; s < DIV_STAGES; s++) begin
        side_r[s] <= side_r[s-1];
      end
    end
  end

  assign side_out = side_r[DIV_STAGES-1];

  // segment adds zone>>1, i.e. the top two fraction bits; x*255 = x*256 - x
  assign seg_nxt  = side_out.seg_base + {{(SEG_W-2){1'b0}}, hue_quo[CH_W-1:CH_W-2]};
  assign full_nxt = {seg_nxt, 8'd0} - {{(FULL_W-SEG_W){1'b0}}, seg_nxt}
                    + {{(FULL_W-8){1'b0}}, hue_quo[7:0]};

  always_ff @(posedge clk) begin
    if (advance) begin
      hue_index_r    <= hue_quo[7:0];
      saturation_r   <= sat_quo;
      value_max_r    <= side_out.mx;
      zone_r         <= hue_quo[CH_W-1:CH_W-3];
      channel_min_r  <= side_out.mn;
      hue_fraction_r <= hue_quo;
      hue_segment_r  <= seg_nxt;
      hue_full_r     <= full_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hue_index    = hue_index_r;
  assign out_saturation   = saturation_r;
  assign out_value_max    = value_max_r;
  assign out_zone         = zone_r;
  assign out_channel_min  = channel_min_r;
  assign out_hue_fraction = hue_fraction_r;
  assign out_hue_segment  = hue_segment_r;
  assign out_hue_full     = hue_full_r;

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (channel_min_r <= value_max_r))
    else $error("channel minimum above maximum");

  a_black_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && value_max_r == '0) |-> (saturation_r == '0))
    else $error("black pixel with nonzero saturation");

  a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && value_max_r == channel_min_r) |-> (hue_fraction_r == '0))
    else $error("grey pixel with nonzero hue fraction");

  a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (hue_segment_r <= 5'd23))
    else $error("hue segment out of range");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(vld_r)))
    else $error("pipeline moved while output stalled");

endmodule

### bench/hsv_result_checker.sv
`timescale 1ns / 1ps
// Watches both channels of the RGB to HSV converter, predicts each pixel and
// compares result beats in order. Depends on rgbhsv_pkg for widths and segment bases.
module hsv_result_checker
  import rgbhsv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [CH_W-1:0]    in_red,
  input  logic [CH_W-1:0]    in_green,
  input  logic [CH_W-1:0]    in_blue,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [7:0]         out_hue_index,
  input  logic [CH_W-1:0]    out_saturation,
  input  logic [CH_W-1:0]    out_value_max,
  input  logic [2:0]         out_zone,
  input  logic [CH_W-1:0]    out_channel_min,
  input  logic [CH_W-1:0]    out_hue_fraction,
  input  logic [SEG_W-1:0]   out_hue_segment,
  input  logic [FULL_W-1:0]  out_hue_full,
  output int                 mismatch_count,
  output int                 pixels_pending,
  output int                 pixels_checked,
  output int                 backpressure_cycles
);

  localparam int MAX_PRINTED = 30;

  typedef struct packed {
    logic [7:0]        hue_index;
    logic [CH_W-1:0]   saturation;
    logic [CH_W-1:0]   value_max;
    logic [2:0]        zone;
    logic [CH_W-1:0]   channel_min;
    logic [CH_W-1:0]   hue_fraction;
    logic [SEG_W-1:0]  hue_segment;
    logic [FULL_W-1:0] hue_full;
  } hsv_pixel_t;

  hsv_pixel_t expected_hsv_q[$];
  int         printed_lines;

  // floor(1024*num/den), capped; a zero divisor gives zero
  function automatic logic [CH_W-1:0] scaled_ratio(input logic [CH_W-1:0] num,
                                                  input logic [CH_W-1:0] den);
    logic [2*CH_W-1:0] q;
    if (den == '0) return '0;
    q = {num, {CH_W{1'b0}}} / {{CH_W{1'b0}}, den};
    return (q > {{CH_W{1'b0}}, QUO_CAP}) ? QUO_CAP : q[CH_W-1:0];
  endfunction

  function automatic hsv_pixel_t hsv_of_rgb(input logic [CH_W-1:0] r,
                                           input logic [CH_W-1:0] g,
                                           input logic [CH_W-1:0] b);
    hsv_pixel_t       px;
    logic [CH_W-1:0]  hi;
    logic [CH_W-1:0]  lo;
    logic [CH_W-1:0]  dividend;
    logic [SEG_W-1:0] base;
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    // red wins ties with either channel, green wins a tie with blue
    if (r >= g && r >= b) begin
      dividend = (g >= b) ? g - b : r - b;
      base     = (g >= b) ? SEG_RED_HI : SEG_RED_LO;
    end else if (g >= b) begin
      dividend = (b >= r) ? b - r : g - r;
      base     = (r <= b) ? SEG_GREEN_HI : SEG_GREEN_LO;
    end else begin
      dividend = (r >= g) ? r - g : b - g;
      base     = (r >= g) ? SEG_BLUE_HI : SEG_BLUE_LO;
    end
    px.value_max    = hi;
    px.channel_min  = lo;
    px.saturation   = scaled_ratio(hi - lo, hi);
    px.hue_fraction = scaled_ratio(dividend, hi - lo);
    px.zone         = px.hue_fraction[9:7];
    px.hue_index    = px.hue_fraction[7:0];
    px.hue_segment  = base + {3'b000, px.zone[2:1]};
    px.hue_full     = FULL_W'(px.hue_segment) * 13'd255 + FULL_W'(px.hue_index);
    return px;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatch_count++;
    if (printed_lines < MAX_PRINTED) begin
      printed_lines++;
      $display("[%0t] pixel %0d: %s is %0d, expected %0d",
               $realtime, pixels_checked, field, got, want);
    end
  endtask

  always @(posedge clk) begin
    hsv_pixel_t want;
    if (!rst_n) begin
      mismatch_count      = 0;
      pixels_pending      = 0;
      pixels_checked      = 0;
      backpressure_cycles = 0;
      printed_lines       = 0;
      expected_hsv_q.delete();
    end else begin
      // retire the result beat first; a pixel taken on this edge cannot be it
      if (out_valid && !out_stall) begin
        if (expected_hsv_q.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          want = expected_hsv_q.pop_front();
          if (out_hue_index != want.hue_index)
            report_mismatch("hue_index", int'(out_hue_index), int'(want.hue_index));
          if (out_saturation != want.saturation)
            report_mismatch("saturation", int'(out_saturation), int'(want.saturation));
          if (out_value_max != want.value_max)
            report_mismatch("value_max", int'(out_value_max), int'(want.value_max));
          if (out_zone != want.zone)
            report_mismatch("zone", int'(out_zone), int'(want.zone));
          if (out_channel_min != want.channel_min)
            report_mismatch("channel_min", int'(out_channel_min),
                            int'(want.channel_min));
          if (out_hue_fraction != want.hue_fraction)
            report_mismatch("hue_fraction", int'(out_hue_fraction),
                            int'(want.hue_fraction));
          if (out_hue_segment != want.hue_segment)
            report_mismatch("hue_segment", int'(out_hue_segment),
                            int'(want.hue_segment));
          if (out_hue_full != want.hue_full)
            report_mismatch("hue_full", int'(out_hue_full), int'(want.hue_full));
          pixels_checked++;
        end
      end
      if (in_valid && in_stall) backpressure_cycles++;
      if (in_valid && !in_stall) expected_hsv_q.push_back(hsv_of_rgb(in_red, in_green, in_blue));
      pixels_pending = expected_hsv_q.size();
    end
  end

endmodule

### bench/tb_rgb_to_hsv_fixed_point.sv
`timescale 1ns / 1ps
// Top of the RGB to HSV converter bench: clock, reset, pixel stimulus and verdict.
// Depends on rgbhsv_pkg, rgb_to_hsv_fixed_point and hsv_result_checker.
module tb_rgb_to_hsv_fixed_point;
  import rgbhsv_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int LONG_HOLD      = 60;
  localparam int DRAIN_TAIL     = 16;
  localparam int PRESSURE_BEATS = 40;
  localparam int RANDOM_PHASE   = 367;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [CH_W-1:0]    in_red;
  logic [CH_W-1:0]    in_green;
  logic [CH_W-1:0]    in_blue;
  logic               out_valid;
  logic               out_stall;
  logic [7:0]         out_hue_index;
  logic [CH_W-1:0]    out_saturation;
  logic [CH_W-1:0]    out_value_max;
  logic [2:0]         out_zone;
  logic [CH_W-1:0]    out_channel_min;
  logic [CH_W-1:0]    out_hue_fraction;
  logic [SEG_W-1:0]   out_hue_segment;
  logic [FULL_W-1:0]  out_hue_full;

  int   mismatch_count;
  int   pixels_pending;
  int   pixels_checked;
  int   backpressure_cycles;
  int   cycle_count = 0;
  int   tx_idle_pct = 34;
  int   rx_idle_pct = 54;
  logic hold_ticket = 1'b0;

  rgb_to_hsv_fixed_point u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hue_index    (out_hue_index),
    .out_saturation   (out_saturation),
    .out_value_max    (out_value_max),
    .out_zone         (out_zone),
    .out_channel_min  (out_channel_min),
    .out_hue_fraction (out_hue_fraction),
    .out_hue_segment  (out_hue_segment),
    .out_hue_full     (out_hue_full)
  );

  hsv_result_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_red              (in_red),
    .in_green            (in_green),
    .in_blue             (in_blue),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_hue_index       (out_hue_index),
    .out_saturation      (out_saturation),
    .out_value_max       (out_value_max),
    .out_zone            (out_zone),
    .out_channel_min     (out_channel_min),
    .out_hue_fraction    (out_hue_fraction),
    .out_hue_segment     (out_hue_segment),
    .out_hue_full        (out_hue_full),
    .mismatch_count      (mismatch_count),
    .pixels_pending      (pixels_pending),
    .pixels_checked      (pixels_checked),
    .backpressure_cycles (backpressure_cycles)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("timed out after %0d cycles", cycle_count);
    $display("status: fail");
    $finish;
  end

  // Receiver: random stalls, or a long hold each time the ticket flips
  initial begin
    int   hold_left;
    logic seen_ticket;
    hold_left   = 0;
    seen_ticket = 1'b0;
    out_stall   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ticket != seen_ticket) begin
        seen_ticket = hold_ticket;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Enter at a falling edge; leave at the falling edge after the beat is taken
  task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                            input logic [CH_W-1:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Mostly ties, greys, narrow spans and zeroed channels, where the dividers' corners live
  task automatic send_random_pixel();
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    r = CH_W'($urandom_range(1023));
    g = CH_W'($urandom_range(1023));
    b = CH_W'($urandom_range(1023));
    case ($urandom_range(11))
      0: g = r;
      1: b = g;
      2: r = b;
      3: begin
        g = r;
        b = r;
      end
      4: begin
        r = CH_W'($urandom_range(7));
        g = CH_W'($urandom_range(7));
        b = CH_W'($urandom_range(7));
      end
      5: r = '0;
      6: g = '0;
      7: b = '0;
      8: begin
        g = (r > 10'd1020) ? r - CH_W'($urandom_range(3)) : r + CH_W'($urandom_range(3));
        b = (r > 10'd1020) ? r - CH_W'($urandom_range(3)) : r + CH_W'($urandom_range(3));
      end
      default: ;
    endcase
    send_pixel(r, g, b);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pixels_pending != 0) @(negedge clk);
  endtask

  task automatic run_random(input int beats, input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    repeat (beats) send_random_pixel();
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_red   = '0;
    in_green = '0;
    in_blue  = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // black, white and greys
    send_pixel(10'd0, 10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023, 10'd1023);
    send_pixel(10'd512, 10'd512, 10'd512);
    send_pixel(10'd1, 10'd1, 10'd1);
    // primaries: saturation quotient hits 1024 and is capped
    send_pixel(10'd1023, 10'd0, 10'd0);
    send_pixel(10'd0, 10'd1023, 10'd0);
    send_pixel(10'd0, 10'd0, 10'd1023);
    send_pixel(10'd1, 10'd0, 10'd0);
    send_pixel(10'd0, 10'd0, 10'd1);
    // ties at the top; all but the third cap the hue quotient
    send_pixel(10'd1023, 10'd1023, 10'd0);
    send_pixel(10'd0, 10'd1023, 10'd1023);
    send_pixel(10'd1023, 10'd0, 10'd1023);
    send_pixel(10'd700, 10'd700, 10'd699);
    // each dominant channel with both orderings of the other two
    send_pixel(10'd1023, 10'd600, 10'd100);
    send_pixel(10'd1023, 10'd100, 10'd600);
    send_pixel(10'd300, 10'd1023, 10'd800);
    send_pixel(10'd800, 10'd1023, 10'd300);
    send_pixel(10'd700, 10'd200, 10'd1023);
    send_pixel(10'd200, 10'd700, 10'd1023);
    send_pixel(10'd1023, 10'd1022, 10'd0);
    send_pixel(10'd682, 10'd341, 10'd0);
    send_pixel(10'd341, 10'd682, 10'd1023);
    wait_for_results();

    // hold the receiver off while pixels keep coming, so the pipe fills
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_ticket <= ~hold_ticket;
    repeat (PRESSURE_BEATS) send_random_pixel();
    wait_for_results();

    run_random(RANDOM_PHASE, 34, 54);
    run_random(RANDOM_PHASE, 54, 34);
    run_random(RANDOM_PHASE, 0, 0);
    wait_for_results();
    repeat (DRAIN_TAIL) @(negedge clk);

    $display("checked %0d pixels: greys, primaries, ties, narrow spans and random colours",
             pixels_checked);
    $display("idling swapped between sides, one long receiver hold (%0d stalled input cycles)",
             backpressure_cycles);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
sv/rgbhsv_pkg.sv
sv/rgbhsv_div.sv
sv/rgb_to_hsv_fixed_point.sv
bench/hsv_result_checker.sv
bench/tb_rgb_to_hsv_fixed_point.sv
